// ===== hw/rtl/sat_pkg.sv =====
// ----------------------------------------------------------------------------
// sat_pkg: shared types and constants of the separating-axis overlap test
// Field widths, load codes, default capacities and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam int FUNC_W = 2;
	localparam int COMP_W = 16;
	localparam int VEC_W  = 3 * COMP_W;
	localparam int PROD_W = 2 * COMP_W;
	localparam int DOT_W  = PROD_W + 3;
	localparam int SEP_W  = 5;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int MAX_AXES_DEF     = 32;

	// Load codes carried in the func field.
	localparam logic [FUNC_W-1:0] FUNC_VERT_A = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_VERT_B = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_AXIS   = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // a request is accepted this cycle
		logic start;      // the accepted request carries last
		logic ax_lat;     // capture the axis read from the axis store
		logic sw_run;     // one vertex sweep step
		logic k_inc;      // move on to the next axis
		logic sep_found;  // the current axis separates the shapes
		logic res_wr;     // write the result register and clear the load
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;      // a shape or the axis list is empty
		logic sw_last;    // the sweep index is on its last vertex
		logic ax_last;    // the current axis is the last one loaded
		logic busy;       // projections are still in flight
		logic sep;        // the two intervals do not overlap
	} dp_sts_t;

endpackage

// ===== hw/rtl/sat_ram.sv =====
// ----------------------------------------------------------------------------
// sat_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sat_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/sat_dp.sv =====
// ----------------------------------------------------------------------------
// sat_dp: datapath of the separating-axis overlap test
// Vertex and axis stores, load counters, the projection pipeline, interval
// tracking and the result register.
// ----------------------------------------------------------------------------
module sat_dp #(
	parameter int MAX_VERTICES = sat_pkg::MAX_VERTICES_DEF,
	parameter int MAX_AXES     = sat_pkg::MAX_AXES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sat_pkg::dp_cmd_t                  cmd,
	output sat_pkg::dp_sts_t                  sts,
	input  logic [sat_pkg::FUNC_W-1:0]        func,
	input  logic signed [sat_pkg::COMP_W-1:0] x,
	input  logic signed [sat_pkg::COMP_W-1:0] y,
	input  logic signed [sat_pkg::COMP_W-1:0] z,
	output logic                              collided,
	output logic [sat_pkg::SEP_W-1:0]         separating_axis,
	output logic                              overflow
);
	import sat_pkg::*;

	localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int VCW = $clog2(MAX_VERTICES + 1);
	localparam int AAW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
	localparam int ACW = $clog2(MAX_AXES + 1);

	function automatic logic signed [PROD_W-1:0] mul_c(input logic [COMP_W-1:0] a,
	                                                  input logic [COMP_W-1:0] b);
		return PROD_W'($signed(a)) * PROD_W'($signed(b));
	endfunction

	logic [VCW-1:0] cnt_a_q;
	logic [VCW-1:0] cnt_b_q;
	logic [ACW-1:0] cnt_ax_q;
	logic           drop_q;
	logic           full_a;
	logic           full_b;
	logic           full_ax;
	logic           we_a;
	logic           we_b;
	logic           we_ax;
	logic [VEC_W-1:0] wvec;

	logic [VAW-1:0] j_q;
	logic [AAW-1:0] k_q;
	logic [VCW-1:0] jmax;

	logic [VEC_W-1:0] rd_a;
	logic [VEC_W-1:0] rd_b;
	logic [VEC_W-1:0] rd_ax;
	logic [VEC_W-1:0] ax_q;

	logic va_r, vb_r, first_r;
	logic va_s1, vb_s1, first_s1;
	logic va_s2, vb_s2, first_s2;
	logic signed [PROD_W-1:0] pa_s1 [3];
	logic signed [PROD_W-1:0] pb_s1 [3];
	logic signed [DOT_W-1:0]  da_s2;
	logic signed [DOT_W-1:0]  db_s2;
	logic signed [DOT_W-1:0]  alo_q, ahi_q, blo_q, bhi_q;

	logic hit_q;
	logic collided_q;
	logic [SEP_W-1:0] sep_q;
	logic ovf_q;

	assign full_a  = (cnt_a_q == VCW'(MAX_VERTICES));
	assign full_b  = (cnt_b_q == VCW'(MAX_VERTICES));
	assign full_ax = (cnt_ax_q == ACW'(MAX_AXES));
	assign we_a    = cmd.load && (func == FUNC_VERT_A) && !full_a;
	assign we_b    = cmd.load && (func == FUNC_VERT_B) && !full_b;
	assign we_ax   = cmd.load && (func == FUNC_AXIS) && !full_ax;
	assign wvec    = {x, y, z};

	// Load counters and the dropped flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			cnt_ax_q <= '0;
			drop_q   <= 1'b0;
		end else if (cmd.res_wr) begin
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			cnt_ax_q <= '0;
			drop_q   <= 1'b0;
		end else if (cmd.load) begin
			unique case (func)
				FUNC_VERT_A: begin
					if (full_a) drop_q <= 1'b1;
					else cnt_a_q <= cnt_a_q + VCW'(1);
				end
				FUNC_VERT_B: begin
					if (full_b) drop_q <= 1'b1;
					else cnt_b_q <= cnt_b_q + VCW'(1);
				end
				FUNC_AXIS: begin
					if (full_ax) drop_q <= 1'b1;
					else cnt_ax_q <= cnt_ax_q + ACW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	sat_ram #(.WIDTH(VEC_W), .DEPTH(MAX_VERTICES)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[VAW-1:0]),
		.wdata (wvec),
		.raddr (j_q),
		.rdata (rd_a)
	);

	sat_ram #(.WIDTH(VEC_W), .DEPTH(MAX_VERTICES)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[VAW-1:0]),
		.wdata (wvec),
		.raddr (j_q),
		.rdata (rd_b)
	);

	sat_ram #(.WIDTH(VEC_W), .DEPTH(MAX_AXES)) u_ram_ax (
		.clk   (clk),
		.we    (we_ax),
		.waddr (cnt_ax_q[AAW-1:0]),
		.wdata (wvec),
		.raddr (k_q),
		.rdata (rd_ax)
	);

	// Sweep and axis indexes.
	assign jmax = (cnt_a_q > cnt_b_q) ? cnt_a_q : cnt_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (cmd.ax_lat) j_q <= '0;
			else if (cmd.sw_run) j_q <= j_q + VAW'(1);
			if (cmd.start) k_q <= '0;
			else if (cmd.k_inc) k_q <= k_q + AAW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ax_lat) ax_q <= rd_ax;
	end

	// Valid flags of the projection pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_r  <= 1'b0;
			vb_r  <= 1'b0;
			va_s1 <= 1'b0;
			vb_s1 <= 1'b0;
			va_s2 <= 1'b0;
			vb_s2 <= 1'b0;
		end else begin
			va_r  <= cmd.sw_run && (VCW'(j_q) < cnt_a_q);
			vb_r  <= cmd.sw_run && (VCW'(j_q) < cnt_b_q);
			va_s1 <= va_r;
			vb_s1 <= vb_r;
			va_s2 <= va_s1;
			vb_s2 <= vb_s1;
		end
	end

	// Products, then dot products, then the interval update.
	always_ff @(posedge clk) begin
		first_r  <= (j_q == '0);
		first_s1 <= first_r;
		first_s2 <= first_s1;
		for (int c = 0; c < 3; c++) begin
			pa_s1[c] <= mul_c(rd_a[c*COMP_W +: COMP_W], ax_q[c*COMP_W +: COMP_W]);
			pb_s1[c] <= mul_c(rd_b[c*COMP_W +: COMP_W], ax_q[c*COMP_W +: COMP_W]);
		end
		da_s2 <= DOT_W'(pa_s1[0]) + DOT_W'(pa_s1[1]) + DOT_W'(pa_s1[2]);
		db_s2 <= DOT_W'(pb_s1[0]) + DOT_W'(pb_s1[1]) + DOT_W'(pb_s1[2]);
		if (va_s2) begin
			if (first_s2 || (da_s2 < alo_q)) alo_q <= da_s2;
			if (first_s2 || (da_s2 > ahi_q)) ahi_q <= da_s2;
		end
		if (vb_s2) begin
			if (first_s2 || (db_s2 < blo_q)) blo_q <= db_s2;
			if (first_s2 || (db_s2 > bhi_q)) bhi_q <= db_s2;
		end
	end

	// Test outcome and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b1;
		end else if (cmd.start) begin
			hit_q <= 1'b1;
		end else if (cmd.sep_found) begin
			hit_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_wr) begin
			collided_q <= hit_q;
			sep_q      <= hit_q ? '0 : SEP_W'(k_q);
			ovf_q      <= drop_q;
		end
	end

	assign collided        = collided_q;
	assign separating_axis = sep_q;
	assign overflow        = ovf_q;

	assign sts.empty   = (cnt_a_q == '0) || (cnt_b_q == '0) || (cnt_ax_q == '0);
	assign sts.sw_last = ((VCW'(j_q) + VCW'(1)) == jmax);
	assign sts.ax_last = ((ACW'(k_q) + ACW'(1)) == cnt_ax_q);
	assign sts.busy    = va_r || vb_r || va_s1 || vb_s1 || va_s2 || vb_s2;
	assign sts.sep     = (ahi_q < blo_q) || (bhi_q < alo_q);

endmodule

// ===== hw/rtl/sat_ctrl.sv =====
// ----------------------------------------------------------------------------
// sat_ctrl: controller of the separating-axis overlap test
// Sequences loading, the per-axis vertex sweep and the result handshake.
// ----------------------------------------------------------------------------
module sat_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output sat_pkg::dp_cmd_t cmd,
	input  sat_pkg::dp_sts_t sts
);
	import sat_pkg::*;

	typedef enum logic [5:0] {
		S_LOAD  = 6'b000001,
		S_AXRD  = 6'b000010,
		S_AXLAT = 6'b000100,
		S_SWEEP = 6'b001000,
		S_DRAIN = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == S_LOAD);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_LOAD: begin
				cmd.load  = accept;
				cmd.start = accept && in_last;
				if (accept && in_last) state_d = S_AXRD;
			end
			S_AXRD: begin
				// An empty shape or axis list can not separate anything.
				if (sts.empty) state_d = S_FIN;
				else state_d = S_AXLAT;
			end
			S_AXLAT: begin
				cmd.ax_lat = 1'b1;
				state_d    = S_SWEEP;
			end
			S_SWEEP: begin
				cmd.sw_run = 1'b1;
				if (sts.sw_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!sts.busy) begin
					if (sts.sep) begin
						cmd.sep_found = 1'b1;
						state_d       = S_FIN;
					end else if (sts.ax_last) begin
						state_d = S_FIN;
					end else begin
						cmd.k_inc = 1'b1;
						state_d   = S_AXRD;
					end
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_wr = 1'b1;
					state_d    = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_wr) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/separating_axis_overlap_test_top.sv =====
// ----------------------------------------------------------------------------
// separating_axis_overlap_test_top: convex shape overlap test by separating axes
// Loads two vertex sets and a list of candidate axes, then reports whether
// any axis separates the two shapes.
// ----------------------------------------------------------------------------
// Each input request loads one 3-vector (signed Q8.8 components) as a vertex
// of shape A, a vertex of shape B or a candidate axis, according to func, and
// a loading request is taken in the cycle in which it is offered. A request
// with last set is loaded like any other and then starts the test; no request
// is accepted until the test has finished and its result has been placed in
// the output register. For every axis in load order, the test reads the axis
// from its store, captures it and then sweeps both vertex stores side by side,
// one vertex of each per cycle, through a three-stage multiply, sum and
// min/max pipeline. The test stops at the first axis whose projected
// intervals do not overlap; intervals that only touch count as overlapping.
// A test in which a shape or the axis list is empty always reports a
// collision. Projections are exact 35-bit dot products with no rounding.
// A request that finds its store full is dropped and sets overflow in the
// next result. The result request carries collided, the index of the first
// separating axis (low five bits, zero when collided) and overflow; a result
// that waits on the output does not block loading of the next shapes, and
// after each test all stores start empty again.
module separating_axis_overlap_test_top #(
	parameter int MAX_VERTICES = sat_pkg::MAX_VERTICES_DEF,
	parameter int MAX_AXES     = sat_pkg::MAX_AXES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sat_pkg::FUNC_W-1:0]        func,
	input  logic signed [sat_pkg::COMP_W-1:0] x,
	input  logic signed [sat_pkg::COMP_W-1:0] y,
	input  logic signed [sat_pkg::COMP_W-1:0] z,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              collided,
	output logic [sat_pkg::SEP_W-1:0]         separating_axis,
	output logic                              overflow
);
	import sat_pkg::*;

	// Command and status bundles between the controller and the datapath.
	dp_cmd_t cmd;
	dp_sts_t sts;

	// The controller owns the handshakes and the test sequence.
	sat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the stores, the projection pipeline and the result.
	sat_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_AXES     (MAX_AXES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.func            (func),
		.x               (x),
		.y               (y),
		.z               (z),
		.collided        (collided),
		.separating_axis (separating_axis),
		.overflow        (overflow)
	);

endmodule
